// ===== rtl/stk_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted key table: action codes, field widths and the
// control bundle that the table drives into its row of key cells.

package stk_pkg;

   localparam int KEY_W = 32;
   localparam int ACT_W = 3;
   localparam int POS_W = 7;
   localparam int FIDX_W = 6;
   localparam int CNT_W = 7;

   localparam logic [ACT_W-1:0] ACT_INSERT_ORDERED = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT_AT      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FIND_BINARY    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FIND_LINEAR    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DELETE         = 3'd4;
   localparam logic [ACT_W-1:0] ACT_CLEAR          = 3'd5;

   typedef struct packed {
      logic cmp;       // latch eq/gt flags against the broadcast key
      logic shift_up;  // open a gap at the broadcast position and write the broadcast key into it
      logic shift_dn;  // close the slot at the broadcast position
   } cell_ctl_type;

endpackage

// ===== rtl/stk_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sorted key table.
// Depends on stk_pkg for field widths.

interface stk_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [stk_pkg::ACT_W-1:0]             action;
   logic signed [stk_pkg::KEY_W-1:0]      key;
   logic [stk_pkg::POS_W-1:0]             position;

   modport source (output valid, action, key, position, input ready);
   modport sink   (input valid, action, key, position, output ready);
endinterface

interface stk_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  success;
   logic [stk_pkg::FIDX_W-1:0]            found_index;
   logic [stk_pkg::CNT_W-1:0]             count;

   modport source (output valid, success, found_index, count, input ready);
   modport sink   (input valid, success, found_index, count, output ready);
endinterface

// ===== rtl/sorted_key_table.sv =====
`timescale 1ns / 1ps
// Sorted key table: CAPACITY signed 32-bit keys in a row of cells with a fill
// count, one response per request. Every request first passes a compare state
// in which all cells compare their key to the request key in parallel; the
// controller then walks the latched flags one probe per cycle, and a shift of
// the whole row is done in a shift state of its own. One request is in flight
// at a time, and a new one is taken while a response waits.
// Depends on stk_pkg, stk_if and stk_cell.

module sorted_key_table #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   stk_req_if.sink    req,
   stk_rsp_if.source  rsp
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMP   = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [stk_pkg::ACT_W-1:0]          act_ff, act_in;
   logic signed [stk_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [stk_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic [CW-1:0]                      lo_ff, lo_in;
   logic [CW-1:0]                      hi_ff, hi_in;
   logic [IW-1:0]                      sh_pos_ff, sh_pos_in;
   logic                               succ_ff, succ_in;
   logic [IW-1:0]                      fidx_ff, fidx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_succ_ff, rsp_succ_in;
   logic [stk_pkg::FIDX_W-1:0]         rsp_fidx_ff, rsp_fidx_in;
   logic [stk_pkg::CNT_W-1:0]          rsp_cnt_ff, rsp_cnt_in;

   stk_pkg::cell_ctl_type              ctl;
   logic signed [stk_pkg::KEY_W-1:0]   cell_key [CAPACITY];
   logic [CAPACITY-1:0]                eq_vec;
   logic [CAPACITY-1:0]                gt_vec;

   logic                               req_take;
   logic                               rsp_free;
   logic [CW-1:0]                      lo_m1;
   logic [CW:0]                        mid_sum;
   logic [CW-1:0]                      mid_w;
   logic [IW-1:0]                      mid;

   // Row of cells; ends fold back onto the broadcast key or themselves.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [stk_pkg::KEY_W-1:0] left_k;
      logic signed [stk_pkg::KEY_W-1:0] right_k;
      if (i == 0) begin : g_lo
         assign left_k = key_ff;
      end else begin : g_lo_n
         assign left_k = cell_key[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi
         assign right_k = cell_key[i];
      end else begin : g_hi_n
         assign right_k = cell_key[i+1];
      end
      stk_cell #(.IDX(i), .IW(IW)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pos       (sh_pos_ff),
         .key_in    (key_ff),
         .left_key  (left_k),
         .right_key (right_k),
         .key_out   (cell_key[i]),
         .eq        (eq_vec[i]),
         .gt        (gt_vec[i])
      );
   end

   assign req.ready = (state_ff == S_IDLE);
   assign req_take  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   assign lo_m1   = lo_ff - CW'(1);
   // floor((lo + hi_excl - 1) / 2), hi_ff holds one past the last candidate
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid_w   = mid_sum[CW:1];
   assign mid     = mid_w[IW-1:0];

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sh_pos_in    = sh_pos_ff;
      succ_in      = succ_ff;
      fidx_in      = fidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_succ_in  = rsp_succ_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ctl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in  = req.action;
               key_in  = req.key;
               pos_in  = req.position;
               succ_in = 1'b0;
               fidx_in = '0;
               hi_in   = cnt_ff;
               lo_in   = (req.action == stk_pkg::ACT_INSERT_ORDERED) ? cnt_ff : '0;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctl.cmp  = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            case (act_ff)
               stk_pkg::ACT_INSERT_ORDERED: begin
                  if (cnt_ff == CAP_CNT) begin
                     state_in = S_DONE;
                  end else if ((lo_ff != '0) && gt_vec[lo_m1[IW-1:0]]) begin
                     lo_in = lo_m1;
                  end else begin
                     sh_pos_in = lo_ff[IW-1:0];
                     state_in  = S_SHIFT;
                  end
               end
               stk_pkg::ACT_INSERT_AT: begin
                  if ((cnt_ff != CAP_CNT) && (32'(pos_ff) <= 32'(cnt_ff))) begin
                     sh_pos_in = IW'(pos_ff);
                     state_in  = S_SHIFT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               stk_pkg::ACT_FIND_BINARY, stk_pkg::ACT_DELETE: begin
                  if (lo_ff >= hi_ff) begin
                     state_in = S_DONE;
                  end else if (eq_vec[mid]) begin
                     if (act_ff == stk_pkg::ACT_DELETE) begin
                        sh_pos_in = mid;
                        state_in  = S_SHIFT;
                     end else begin
                        succ_in  = 1'b1;
                        fidx_in  = mid;
                        state_in = S_DONE;
                     end
                  end else if (gt_vec[mid]) begin
                     hi_in = mid_w;
                  end else begin
                     lo_in = mid_w + CW'(1);
                  end
               end
               stk_pkg::ACT_FIND_LINEAR: begin
                  if (lo_ff >= cnt_ff) begin
                     state_in = S_DONE;
                  end else if (eq_vec[lo_ff[IW-1:0]]) begin
                     succ_in  = 1'b1;
                     fidx_in  = lo_ff[IW-1:0];
                     state_in = S_DONE;
                  end else begin
                     lo_in = lo_ff + CW'(1);
                  end
               end
               stk_pkg::ACT_CLEAR: begin
                  cnt_in   = '0;
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            succ_in = 1'b1;
            if (act_ff == stk_pkg::ACT_DELETE) begin
               ctl.shift_dn = 1'b1;
               cnt_in       = cnt_ff - CW'(1);
            end else begin
               ctl.shift_up = 1'b1;
               cnt_in       = cnt_ff + CW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_succ_in  = succ_ff;
               rsp_fidx_in  = stk_pkg::FIDX_W'(fidx_ff);
               rsp_cnt_in   = stk_pkg::CNT_W'(cnt_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sh_pos_ff   <= sh_pos_in;
      succ_ff     <= succ_in;
      fidx_ff     <= fidx_in;
      rsp_succ_ff <= rsp_succ_in;
      rsp_fidx_ff <= rsp_fidx_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.success     = rsp_succ_ff;
   assign rsp.found_index = rsp_fidx_ff;
   assign rsp.count       = rsp_cnt_ff;

endmodule

// ===== rtl/stk_cell.sv =====
`timescale 1ns / 1ps
// One slot of the key row: holds a key, compares it against the broadcast
// key and takes a neighbor's key during shifts. Depends on stk_pkg.

module stk_cell #(
   parameter int IDX = 0,
   parameter int IW  = 6
) (
   input  logic                              clock,
   input  stk_pkg::cell_ctl_type             ctl,
   input  logic [IW-1:0]                     pos,
   input  logic signed [stk_pkg::KEY_W-1:0]  key_in,
   input  logic signed [stk_pkg::KEY_W-1:0]  left_key,
   input  logic signed [stk_pkg::KEY_W-1:0]  right_key,
   output logic signed [stk_pkg::KEY_W-1:0]  key_out,
   output logic                              eq,
   output logic                              gt
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic signed [stk_pkg::KEY_W-1:0] key_ff;
   logic                             eq_ff;
   logic                             gt_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift_up) begin
         if (MY_IDX > pos) begin
            key_ff <= left_key;
         end else if (MY_IDX == pos) begin
            key_ff <= key_in;
         end
      end else if (ctl.shift_dn && (MY_IDX >= pos)) begin
         key_ff <= right_key;
      end
      if (ctl.cmp) begin
         eq_ff <= (key_ff == key_in);
         gt_ff <= (key_ff > key_in);
      end
   end

   assign key_out = key_ff;
   assign eq      = eq_ff;
   assign gt      = gt_ff;

endmodule

// ===== rtl/stk_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sorted key table, bound to the top level.
// Depends on stk_pkg and the channel interfaces.

module stk_chk #(
   parameter int CAPACITY = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_success,
   input logic [stk_pkg::FIDX_W-1:0]    rsp_found_index,
   input logic [stk_pkg::CNT_W-1:0]     rsp_count
);

   // count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_count) <= CAPACITY))
      else $error("response count above capacity");

   // a failed transaction reports index zero
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_found_index == '0))
      else $error("nonzero index on failed transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
                                     && $stable(rsp_success)))
      else $error("stalled response changed");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sorted_key_table stk_chk #(.CAPACITY(CAPACITY)) u_stk_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_success     (rsp.success),
   .rsp_found_index (rsp.found_index),
   .rsp_count       (rsp.count)
);

// ===== sim/sorted_key_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_key_table: directed table of transactions, then random
// sequences, all checked against an in-bench model of the key table.
// Depends on stk_pkg, stk_if and the RTL of sorted_key_table.

module sorted_key_table_tb;

   localparam int CAP = 64;
   localparam int N_RANDOM = 1510;

   // codes the table does not use
   localparam logic [stk_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [stk_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                         success;
      logic [stk_pkg::FIDX_W-1:0]   found_index;
      logic [stk_pkg::CNT_W-1:0]    count;
   } outcome_type;

   typedef struct {
      logic [stk_pkg::ACT_W-1:0]    action;
      logic [stk_pkg::KEY_W-1:0]    key;
      logic [stk_pkg::POS_W-1:0]    position;
      bit                           typed;     // expected value given in the row
      outcome_type                  want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stk_req_if req ();
   stk_rsp_if rsp ();

   sorted_key_table #(.CAPACITY(CAP)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #5 clock = ~clock;

   // table model
   logic [stk_pkg::KEY_W-1:0] keys_m [CAP];
   int               fill_m;
   outcome_type      pending_q [$];
   int               mismatches = 0;
   int               n_rsp = 0;
   int               n_found = 0;
   bit               calm = 1'b0;   // no idling on either side
   bit               sent_all = 1'b0;

   function automatic bit key_lt(logic [stk_pkg::KEY_W-1:0] a,
                                 logic [stk_pkg::KEY_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic int binary_probe(logic [stk_pkg::KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = fill_m - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (keys_m[mid] == k) return mid;
         if (key_lt(keys_m[mid], k)) lo = mid + 1;
         else hi = mid - 1;
      end
      return -1;
   endfunction

   function automatic outcome_type table_apply(logic [stk_pkg::ACT_W-1:0] act,
                                               logic [stk_pkg::KEY_W-1:0] k,
                                               logic [stk_pkg::POS_W-1:0] pos);
      outcome_type o;
      int j;
      o = '0;
      case (act)
         stk_pkg::ACT_INSERT_ORDERED: begin
            if (fill_m < CAP) begin
               j = fill_m;
               while (j > 0 && key_lt(k, keys_m[j-1])) begin
                  keys_m[j] = keys_m[j-1];
                  j--;
               end
               keys_m[j] = k;
               fill_m++;
               o.success = 1'b1;
            end
         end
         stk_pkg::ACT_INSERT_AT: begin
            if (fill_m < CAP && pos <= fill_m) begin
               for (j = fill_m; j > pos; j--) keys_m[j] = keys_m[j-1];
               keys_m[pos] = k;
               fill_m++;
               o.success = 1'b1;
            end
         end
         stk_pkg::ACT_FIND_BINARY: begin
            j = binary_probe(k);
            if (j >= 0) begin
               o.success = 1'b1;
               o.found_index = j[stk_pkg::FIDX_W-1:0];
            end
         end
         stk_pkg::ACT_FIND_LINEAR: begin
            for (j = 0; j < fill_m; j++) begin
               if (keys_m[j] == k) begin
                  o.success = 1'b1;
                  o.found_index = j[stk_pkg::FIDX_W-1:0];
                  break;
               end
            end
         end
         stk_pkg::ACT_DELETE: begin
            j = binary_probe(k);
            if (j >= 0) begin
               for (; j + 1 < fill_m; j++) keys_m[j] = keys_m[j+1];
               fill_m--;
               o.success = 1'b1;
            end
         end
         stk_pkg::ACT_CLEAR: fill_m = 0;
         default: ;
      endcase
      o.count = fill_m[stk_pkg::CNT_W-1:0];
      return o;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 21);
   endfunction

   // sends one transaction; the model advances on acceptance
   task automatic send(logic [stk_pkg::ACT_W-1:0] act, logic [stk_pkg::KEY_W-1:0] k,
                       logic [stk_pkg::POS_W-1:0] pos, bit typed, outcome_type want);
      outcome_type o;
      while (idle_now()) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.action   <= act;
      req.key      <= k;
      req.position <= pos;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      o = table_apply(act, k, pos);
      if (typed && o != want)
         $display("directed row disagrees with model: act %0d key %h", act, k);
      pending_q.push_back(typed ? want : o);
      // valid stays up; the block is busy after an accept
      @(negedge clock);
   endtask

   // response side
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !idle_now();
   end

   always @(posedge clock) begin
      outcome_type got;
      outcome_type exp_o;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.success, rsp.found_index, rsp.count};
         n_rsp++;
         if (got.success) n_found++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            exp_o = pending_q.pop_front();
            if (got != exp_o) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp succ %0b idx %0d cnt %0d, got succ %0b idx %0d cnt %0d",
                           exp_o.success, exp_o.found_index, exp_o.count,
                           got.success, got.found_index, got.count);
            end
         end
      end
   end

   function automatic logic [stk_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 50) return stk_pkg::KEY_W'($signed($urandom_range(40)) - 20);
      if (r < 60 && fill_m > 0) return keys_m[$urandom_range(fill_m - 1)];
      if (r < 70) return {1'b1, 31'h0};
      if (r < 80) return {1'b0, {31{1'b1}}};
      return $urandom();
   endfunction

   row_type rows [$];

   initial begin
      row_type r;
      int n;
      int act;
      req.valid = 1'b0;
      req.action = stk_pkg::ACT_CLEAR;
      req.key = '0;
      req.position = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, extremes, bad position, duplicates, unused codes
      rows = '{
         '{stk_pkg::ACT_FIND_BINARY,    32'h0000_0005, 7'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
         '{stk_pkg::ACT_FIND_LINEAR,    32'h0000_0005, 7'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
         '{stk_pkg::ACT_DELETE,         32'h0000_0005, 7'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
         '{stk_pkg::ACT_INSERT_AT,      32'h0000_0001, 7'd1,  1'b1, '{1'b0, 6'd0, 7'd0}},
         '{stk_pkg::ACT_INSERT_ORDERED, 32'h7fff_ffff, 7'd0,  1'b1, '{1'b1, 6'd0, 7'd1}},
         '{stk_pkg::ACT_INSERT_ORDERED, 32'h8000_0000, 7'd0,  1'b1, '{1'b1, 6'd0, 7'd2}},
         '{stk_pkg::ACT_INSERT_ORDERED, 32'hffff_ffff, 7'd0,  1'b1, '{1'b1, 6'd0, 7'd3}},
         '{stk_pkg::ACT_FIND_BINARY,    32'h7fff_ffff, 7'd0,  1'b1, '{1'b1, 6'd2, 7'd3}},
         '{stk_pkg::ACT_FIND_LINEAR,    32'h8000_0000, 7'd0,  1'b1, '{1'b1, 6'd0, 7'd3}},
         '{stk_pkg::ACT_INSERT_ORDERED, 32'hffff_ffff, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_INSERT_ORDERED, 32'hffff_ffff, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_FIND_BINARY,    32'hffff_ffff, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_FIND_LINEAR,    32'hffff_ffff, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_INSERT_AT,      32'h0000_0000, 7'd7,  1'b1, '{1'b0, 6'd0, 7'd5}},
         '{stk_pkg::ACT_INSERT_AT,      32'h0000_0063, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_FIND_BINARY,    32'h0000_0063, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_FIND_LINEAR,    32'h0000_0063, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_DELETE,         32'h0000_0063, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_INSERT_AT,      32'h0000_0011, 7'd6,  1'b0, '0},
         '{ACT_SPARE_LO,                32'h1234_5678, 7'd0,  1'b0, '0},
         '{ACT_SPARE_HI,                32'hffff_ffff, 7'd127, 1'b0, '0},
         '{stk_pkg::ACT_DELETE,         32'h8000_0000, 7'd0,  1'b0, '0},
         '{stk_pkg::ACT_CLEAR,          32'h0000_0000, 7'd0,  1'b1, '{1'b0, 6'd0, 7'd0}}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send(r.action, r.key, r.position, r.typed, r.want);
      end

      // fill to capacity, then full-table inserts
      for (int i = 0; i < CAP; i++)
         send(stk_pkg::ACT_INSERT_ORDERED, pick_key(), '0, 1'b0, '0);
      send(stk_pkg::ACT_INSERT_ORDERED, 32'h0, '0, 1'b1, '{1'b0, 6'd0, 7'd64});
      send(stk_pkg::ACT_INSERT_AT, 32'h0, 7'd64, 1'b1, '{1'b0, 6'd0, 7'd64});
      send(stk_pkg::ACT_FIND_LINEAR, keys_m[CAP-1], '0, 1'b0, '0);
      send(stk_pkg::ACT_FIND_BINARY, keys_m[CAP-1], '0, 1'b0, '0);

      // random part; first stretch runs without idling
      n = 0;
      while (n < N_RANDOM) begin
         calm = (n < 300);
         act = $urandom_range(99);
         if (act < 30)      act = stk_pkg::ACT_INSERT_ORDERED;
         else if (act < 40) act = stk_pkg::ACT_INSERT_AT;
         else if (act < 58) act = stk_pkg::ACT_FIND_BINARY;
         else if (act < 72) act = stk_pkg::ACT_FIND_LINEAR;
         else if (act < 93) act = stk_pkg::ACT_DELETE;
         else if (act < 96) act = stk_pkg::ACT_CLEAR;
         else if (act < 98) act = ACT_SPARE_LO;
         else               act = ACT_SPARE_HI;
         send(act[stk_pkg::ACT_W-1:0], pick_key(),
              ($urandom_range(9) == 0) ? stk_pkg::POS_W'($urandom()) :
                                         stk_pkg::POS_W'($urandom_range(fill_m)),
              1'b0, '0);
         n++;
      end
      req.valid <= 1'b0;
      calm = 1'b0;
      sent_all = 1'b1;
   end

   initial begin
      wait (sent_all);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d responses, %0d with success set, all actions and codes",
               n_rsp, n_found);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, pending_q.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sorted_key_table.f =====
rtl/stk_pkg.sv
rtl/stk_if.sv
rtl/stk_cell.sv
rtl/sorted_key_table.sv
rtl/stk_chk.sv
sim/sorted_key_table_tb.sv
